>>> src/aqic_pkg.sv
// ----------------------------------------------------------------------------
// aqic_pkg
// Types, constants and the breakpoint table for the air quality index core.
// ----------------------------------------------------------------------------
`default_nettype none

package aqic_pkg;

	localparam int CONC_W  = 22;
	localparam int INDEX_W = 9;
	localparam int Q_W     = 9;
	localparam int ROM_SEG = 8;

	localparam logic [INDEX_W-1:0] THR_GOOD      = 9'd50;
	localparam logic [INDEX_W-1:0] THR_MODERATE  = 9'd100;
	localparam logic [INDEX_W-1:0] THR_SENSITIVE = 9'd150;
	localparam logic [INDEX_W-1:0] THR_UNHEALTHY = 9'd200;
	localparam logic [INDEX_W-1:0] THR_VERY      = 9'd300;

	localparam logic [2:0] CAT_GOOD      = 3'd0;
	localparam logic [2:0] CAT_MODERATE  = 3'd1;
	localparam logic [2:0] CAT_SENSITIVE = 3'd2;
	localparam logic [2:0] CAT_UNHEALTHY = 3'd3;
	localparam logic [2:0] CAT_VERY      = 3'd4;
	localparam logic [2:0] CAT_HAZARDOUS = 3'd5;

	localparam logic [2:0] POLL_PM25  = 3'd0;
	localparam logic [2:0] POLL_PM10  = 3'd1;
	localparam logic [2:0] POLL_OZONE = 3'd2;
	localparam logic [2:0] POLL_CO    = 3'd3;
	localparam logic [2:0] POLL_SO2   = 3'd4;
	localparam logic [2:0] POLL_NO2   = 3'd5;

	typedef struct packed {
		logic [CONC_W-1:0]  c_lo;
		logic [CONC_W-1:0]  c_hi;
		logic [INDEX_W-1:0] i_lo;
		logic [INDEX_W-1:0] i_hi;
	} seg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	function automatic seg_t mk_seg(input int c_lo, input int c_hi, input int i_lo,
			input int i_hi);
		seg_t s;
		s.c_lo = CONC_W'(c_lo);
		s.c_hi = CONC_W'(c_hi);
		s.i_lo = INDEX_W'(i_lo);
		s.i_hi = INDEX_W'(i_hi);
		return s;
	endfunction

	function automatic logic [3:0] seg_count(input logic [2:0] p);
		logic [3:0] n;
		case (p)
			POLL_OZONE: n = 4'd5;
			POLL_PM25, POLL_PM10, POLL_CO, POLL_SO2, POLL_NO2: n = 4'd6;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic seg_t rom_seg(input logic [2:0] p, input logic [2:0] s);
		seg_t r;
		r = '0;
		case (p)
			POLL_PM25: begin
				case (s)
					3'd0: r = mk_seg(0, 12000, 0, 50);
					3'd1: r = mk_seg(12100, 35400, 51, 100);
					3'd2: r = mk_seg(35500, 55400, 101, 150);
					3'd3: r = mk_seg(55500, 150400, 151, 200);
					3'd4: r = mk_seg(150500, 250400, 201, 300);
					3'd5: r = mk_seg(250500, 500400, 301, 500);
					default: r = '0;
				endcase
			end
			POLL_PM10: begin
				case (s)
					3'd0: r = mk_seg(0, 54000, 0, 50);
					3'd1: r = mk_seg(55000, 154000, 51, 100);
					3'd2: r = mk_seg(155000, 254000, 101, 150);
					3'd3: r = mk_seg(255000, 354000, 151, 200);
					3'd4: r = mk_seg(355000, 424000, 201, 300);
					3'd5: r = mk_seg(425000, 604000, 301, 500);
					default: r = '0;
				endcase
			end
			POLL_OZONE: begin
				case (s)
					3'd0: r = mk_seg(0, 54, 0, 50);
					3'd1: r = mk_seg(55, 70, 51, 100);
					3'd2: r = mk_seg(71, 85, 101, 150);
					3'd3: r = mk_seg(86, 105, 151, 200);
					3'd4: r = mk_seg(106, 200, 201, 300);
					default: r = '0;
				endcase
			end
			POLL_CO: begin
				case (s)
					3'd0: r = mk_seg(0, 4400, 0, 50);
					3'd1: r = mk_seg(4500, 9400, 51, 100);
					3'd2: r = mk_seg(9500, 12400, 101, 150);
					3'd3: r = mk_seg(12500, 15400, 151, 200);
					3'd4: r = mk_seg(15500, 30400, 201, 300);
					3'd5: r = mk_seg(30500, 50400, 301, 500);
					default: r = '0;
				endcase
			end
			POLL_SO2: begin
				case (s)
					3'd0: r = mk_seg(0, 35000, 0, 50);
					3'd1: r = mk_seg(36000, 75000, 51, 100);
					3'd2: r = mk_seg(76000, 185000, 101, 150);
					3'd3: r = mk_seg(186000, 304000, 151, 200);
					3'd4: r = mk_seg(305000, 604000, 201, 300);
					3'd5: r = mk_seg(605000, 1004000, 301, 500);
					default: r = '0;
				endcase
			end
			POLL_NO2: begin
				case (s)
					3'd0: r = mk_seg(0, 53000, 0, 50);
					3'd1: r = mk_seg(54000, 100000, 51, 100);
					3'd2: r = mk_seg(101000, 360000, 101, 150);
					3'd3: r = mk_seg(361000, 649000, 151, 200);
					3'd4: r = mk_seg(650000, 1249000, 201, 300);
					3'd5: r = mk_seg(1250000, 2049000, 301, 500);
					default: r = '0;
				endcase
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] category(input logic [INDEX_W-1:0] aqi);
		logic [2:0] c;
		if (aqi <= THR_GOOD) c = CAT_GOOD;
		else if (aqi <= THR_MODERATE) c = CAT_MODERATE;
		else if (aqi <= THR_SENSITIVE) c = CAT_SENSITIVE;
		else if (aqi <= THR_UNHEALTHY) c = CAT_UNHEALTHY;
		else if (aqi <= THR_VERY) c = CAT_VERY;
		else c = CAT_HAZARDOUS;
		return c;
	endfunction

endpackage

`default_nettype wire

>>> src/aqic_if.sv
// ----------------------------------------------------------------------------
// aqic_if
// Valid/ready channels for readings into and results out of the AQI core.
// ----------------------------------------------------------------------------
`default_nettype none

interface aqic_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         pollutant;
	logic signed [22:0] concentration;
	logic               last_of_set;

	modport source (output valid, output pollutant, output concentration,
		output last_of_set, input ready);
	modport sink (input valid, input pollutant, input concentration,
		input last_of_set, output ready);
endinterface

interface aqic_out_if;
	logic       valid;
	logic       ready;
	logic [8:0] sub_index;
	logic [2:0] sub_category;
	logic       found;
	logic [8:0] overall_index;
	logic [2:0] overall_category;
	logic       set_done;

	modport source (output valid, output sub_index, output sub_category, output found,
		output overall_index, output overall_category, output set_done, input ready);
	modport sink (input valid, input sub_index, input sub_category, input found,
		input overall_index, input overall_category, input set_done, output ready);
endinterface

`default_nettype wire

>>> src/air_quality_index_calc_core.sv
// ----------------------------------------------------------------------------
// air_quality_index_calc_core
// Piecewise linear air quality sub-index per reading with a running set maximum.
// ----------------------------------------------------------------------------
// One reading word is taken when the core is idle; it then walks the breakpoint
// table one segment per cycle. A hit forms the interpolation numerator in a
// multiply step and divides with a restoring divider that settles one quotient
// bit per cycle (nine bits); a miss goes straight to the final step. The divider
// is the dominant cost. The result sits in an output register, so a new reading
// is accepted while the previous result waits; the core only stalls at its final
// step if that register is still full. Negative readings count as zero; a
// reading in a gap or above the table gives a sub-index of zero with found low
// but still joins the set maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module air_quality_index_calc_core
	import aqic_pkg::*;
#(
	parameter int MAX_SEGMENTS   = 6,
	parameter int NUM_POLLUTANTS = 6
) (
	input  wire logic clk,
	input  wire logic arst_n,
	aqic_in_if.sink   sample,
	aqic_out_if.source result
);

	localparam logic [3:0] MAX_SEG_L  = 4'(MAX_SEGMENTS);
	localparam logic [3:0] NUM_POLL_L = 4'(NUM_POLLUTANTS);
	localparam int         REM_W      = 2 * CONC_W + INDEX_W;

	state_t state_q, state_d;

	logic [2:0]         poll_q;
	logic [CONC_W-1:0]  conc_q;
	logic               last_q;
	logic [3:0]         nseg_q;
	logic [3:0]         seg_q;
	logic [CONC_W-1:0]  den_q;
	logic [INDEX_W-1:0] di_q;
	logic [CONC_W-1:0]  off_q;
	logic [INDEX_W-1:0] ilo_q;
	logic               hit_q;
	logic [REM_W-1:0]   rem_q;
	logic [CONC_W:0]    dvs_q;
	logic [Q_W-1:0]     quo_q;
	logic [3:0]         bit_q;
	logic [INDEX_W-1:0] running_max_q;
	logic               out_valid_q;

	seg_t                      seg;
	logic                      seg_end;
	logic                      seg_hit;
	logic [INDEX_W+CONC_W-1:0] prod;
	logic [REM_W-1:0]          trial;
	logic                      trial_ok;
	logic [INDEX_W:0]          sub_sum;
	logic [INDEX_W-1:0]        sub_val;
	logic [INDEX_W-1:0]        overall_val;
	logic                      accept;
	logic                      load_out;

	assign accept  = sample.valid && sample.ready;
	assign seg     = rom_seg(poll_q, seg_q[2:0]);
	assign seg_end = (seg_q >= nseg_q);
	assign seg_hit = (conc_q >= seg.c_lo) && (conc_q <= seg.c_hi);

	assign prod = di_q * off_q;

	// Shared compare/subtract of the divider: divisor scaled to the current bit.
	assign trial    = REM_W'({dvs_q, {(Q_W - 1){1'b0}}}) >> (4'(Q_W - 1) - bit_q);
	assign trial_ok = (rem_q >= trial);

	assign sub_sum     = {1'b0, ilo_q} + {{(INDEX_W + 1 - Q_W){1'b0}}, quo_q};
	assign sub_val     = !hit_q ? '0 : (sub_sum[INDEX_W] ? '1 : sub_sum[INDEX_W-1:0]);
	assign overall_val = (running_max_q > sub_val) ? running_max_q : sub_val;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (sample.valid) state_d = ST_SEARCH;
			ST_SEARCH: begin
				if (seg_end) state_d = ST_DONE;
				else if (seg_hit) state_d = ST_MUL;
			end
			ST_MUL:    state_d = (den_q == '0) ? ST_DONE : ST_DIV;
			ST_DIV:    if (bit_q == 4'd0) state_d = ST_DONE;
			ST_DONE:   if (!out_valid_q || result.ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sample.ready = 1'b0;
		load_out     = 1'b0;
		unique case (state_q)
			ST_IDLE: sample.ready = 1'b1;
			ST_DONE: load_out = !out_valid_q || result.ready;
			default: begin
				sample.ready = 1'b0;
				load_out     = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			running_max_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				running_max_q <= last_q ? '0 : overall_val;
				out_valid_q   <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			poll_q <= sample.pollutant;
			conc_q <= sample.concentration[22] ? '0 : sample.concentration[CONC_W-1:0];
			last_q <= sample.last_of_set;
			if ({1'b0, sample.pollutant} < NUM_POLL_L) begin
				nseg_q <= (seg_count(sample.pollutant) > MAX_SEG_L) ? MAX_SEG_L
					: seg_count(sample.pollutant);
			end else begin
				nseg_q <= 4'd0;
			end
			seg_q <= 4'd0;
			hit_q <= 1'b0;
			quo_q <= '0;
		end
		if (state_q == ST_SEARCH && !seg_end) begin
			if (seg_hit) begin
				hit_q <= 1'b1;
				den_q <= seg.c_hi - seg.c_lo;
				di_q  <= seg.i_hi - seg.i_lo;
				off_q <= conc_q - seg.c_lo;
				ilo_q <= seg.i_lo;
			end else begin
				seg_q <= seg_q + 4'd1;
			end
		end
		if (state_q == ST_MUL) begin
			// Rounded half up: (2 * num + den) / (2 * den).
			rem_q <= REM_W'({prod, 1'b0}) + REM_W'(den_q);
			dvs_q <= {den_q, 1'b0};
			bit_q <= 4'(Q_W - 1);
		end
		if (state_q == ST_DIV) begin
			if (trial_ok) begin
				rem_q        <= rem_q - trial;
				quo_q[bit_q[$clog2(Q_W)-1:0]] <= 1'b1;
			end
			bit_q <= bit_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result.sub_index        <= sub_val;
			result.sub_category     <= category(sub_val);
			result.found            <= hit_q;
			result.overall_index    <= overall_val;
			result.overall_category <= category(overall_val);
			result.set_done         <= last_q;
		end
	end

	assign result.valid = out_valid_q;

	a_overall_ge_sub: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.overall_index >= result.sub_index)
		else $error("overall index below sub-index");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.found |-> result.sub_index == '0)
		else $error("nonzero sub-index without a segment hit");

	a_quotient_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && bit_q == 4'(Q_W - 1)
			|-> rem_q < (REM_W'({dvs_q, {(Q_W - 1){1'b0}}}) << 1))
		else $error("quotient overflows divider width");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !sample.ready)
		else $error("core ready again right after taking a word");

endmodule

`default_nettype wire

>>> tb/tb_air_quality_index_calc_core.sv
// ----------------------------------------------------------------------------
// tb_air_quality_index_calc_core
// Self-checking bench for the AQI core: readings in, sub-index results out.
// ----------------------------------------------------------------------------
// A queue of readings feeds a bursty driver. Each accepted word is scored
// by a breakpoint-table model kept in this file. Scoring covers clamping,
// segment search, half-up interpolation, categories and the running set
// maximum. The monitor checks every result word against the oldest
// prediction. The receiver stalls on a rotating pattern and twice holds off
// long enough to back the core up. The driver also drains the core now and
// then before it offers the next word.
// ----------------------------------------------------------------------------

module tb_air_quality_index_calc_core;
	timeunit 1ns;
	timeprecision 1ps;

	import aqic_pkg::*;

	localparam int NUM_POLL     = 6;
	localparam int RANDOM_ITEMS = 928;
	localparam int IDLE_LIMIT   = 3000;
	localparam int TAIL_CYCLES  = 40;
	localparam int SHOW_ERRORS  = 10;

	typedef struct packed {
		logic [2:0]         pollutant;
		logic signed [22:0] concentration;
		logic               last_of_set;
		logic               hold_back;
	} reading_t;

	typedef struct packed {
		logic [INDEX_W-1:0] sub_index;
		logic [2:0]         sub_category;
		logic               found;
		logic [INDEX_W-1:0] overall_index;
		logic [2:0]         overall_category;
		logic               set_done;
	} aqi_result_t;

	// Breakpoint table, rows in pollutant code order, thousandths of the unit.
	int unsigned bp_count [NUM_POLL] = '{6, 6, 5, 6, 6, 6};
	int unsigned bp_c_lo [NUM_POLL][6] = '{
		'{0, 12100, 35500, 55500, 150500, 250500},
		'{0, 55000, 155000, 255000, 355000, 425000},
		'{0, 55, 71, 86, 106, 0},
		'{0, 4500, 9500, 12500, 15500, 30500},
		'{0, 36000, 76000, 186000, 305000, 605000},
		'{0, 54000, 101000, 361000, 650000, 1250000}
	};
	int unsigned bp_c_hi [NUM_POLL][6] = '{
		'{12000, 35400, 55400, 150400, 250400, 500400},
		'{54000, 154000, 254000, 354000, 424000, 604000},
		'{54, 70, 85, 105, 200, 0},
		'{4400, 9400, 12400, 15400, 30400, 50400},
		'{35000, 75000, 185000, 304000, 604000, 1004000},
		'{53000, 100000, 360000, 649000, 1249000, 2049000}
	};
	int unsigned bp_i_lo [6] = '{0, 51, 101, 151, 201, 301};
	int unsigned bp_i_hi [6] = '{50, 100, 150, 200, 300, 500};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	aqic_in_if  sample_if ();
	aqic_out_if result_if ();

	air_quality_index_calc_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_if.sink),
		.result (result_if.source)
	);

	reading_t    pending_q [$];
	aqi_result_t expected_q [$];

	logic [INDEX_W-1:0] set_max;
	int error_count  = 0;
	int results_done = 0;
	int hit_count    = 0;
	int miss_count   = 0;
	int sets_closed  = 0;
	int long_holds   = 0;
	int idle_cycles  = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [2:0] aqi_band(input int unsigned v);
		if (v <= int'(THR_GOOD)) return CAT_GOOD;
		if (v <= int'(THR_MODERATE)) return CAT_MODERATE;
		if (v <= int'(THR_SENSITIVE)) return CAT_SENSITIVE;
		if (v <= int'(THR_UNHEALTHY)) return CAT_UNHEALTHY;
		if (v <= int'(THR_VERY)) return CAT_VERY;
		return CAT_HAZARDOUS;
	endfunction

	// Scores one reading and advances the set maximum.
	function automatic aqi_result_t score_reading(input reading_t r);
		aqi_result_t res;
		longint unsigned conc;
		longint unsigned span;
		longint unsigned num;
		longint unsigned q;
		int unsigned sub;
		int unsigned overall;
		int unsigned p;
		int s;
		bit hit;
		conc = r.concentration[22] ? 64'd0 : 64'(r.concentration[21:0]);
		p = r.pollutant;
		sub = 0;
		hit = 1'b0;
		if (p < NUM_POLL) begin
			for (s = 0; s < int'(bp_count[p]); s++) begin
				if (!hit && conc >= bp_c_lo[p][s] && conc <= bp_c_hi[p][s]) begin
					span = bp_c_hi[p][s] - bp_c_lo[p][s];
					num = 64'(bp_i_hi[s] - bp_i_lo[s]) * (conc - bp_c_lo[p][s]);
					q = (span == 0) ? 64'd0 : (2 * num + span) / (2 * span);
					sub = bp_i_lo[s] + int'(q);
					if (sub > 511) sub = 511;
					hit = 1'b1;
				end
			end
		end
		overall = (int'(set_max) > sub) ? int'(set_max) : sub;
		set_max = r.last_of_set ? '0 : INDEX_W'(overall);
		res.sub_index        = INDEX_W'(sub);
		res.sub_category     = aqi_band(sub);
		res.found            = hit;
		res.overall_index    = INDEX_W'(overall);
		res.overall_category = aqi_band(overall);
		res.set_done         = r.last_of_set;
		return res;
	endfunction

	task automatic queue_reading(input logic [2:0] p, input int c, input bit last,
			input bit hold);
		reading_t r;
		r.pollutant     = p;
		r.concentration = 23'(c);
		r.last_of_set   = last;
		r.hold_back     = hold;
		pending_q.push_back(r);
	endtask

	task automatic note_failure(input string what);
		error_count++;
		if (error_count <= SHOW_ERRORS)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Driver: bursts of words with random gaps; a hold_back word waits until
	// every outstanding result has come back.
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		int nb;
		int ng;
		bit took;
		bit offer;
		if (!arst_n) begin
			sample_if.valid         <= 1'b0;
			sample_if.pollutant     <= POLL_PM25;
			sample_if.concentration <= '0;
			sample_if.last_of_set   <= 1'b0;
			burst_left              <= 8;
			gap_left                <= 0;
			set_max                 = '0;
		end else begin
			nb = burst_left;
			ng = gap_left;
			took = sample_if.valid && sample_if.ready;
			if (took) begin
				expected_q.push_back(score_reading(pending_q.pop_front()));
				nb--;
				if (nb <= 0) begin
					nb = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
						: $urandom_range(1, 12);
					ng = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 30);
				end
			end
			if (sample_if.valid && !took)
				offer = 1'b1;
			else if (ng != 0) begin
				ng--;
				offer = 1'b0;
			end else
				offer = pending_q.size() != 0
					&& (!pending_q[0].hold_back || expected_q.size() == 0);
			sample_if.valid <= offer;
			if (offer) begin
				sample_if.pollutant     <= pending_q[0].pollutant;
				sample_if.concentration <= pending_q[0].concentration;
				sample_if.last_of_set   <= pending_q[0].last_of_set;
			end
			burst_left <= nb;
			gap_left   <= ng;
		end
	end

	// Receiver: a rotating stall pattern, plus long hold-offs that back the
	// core up into its input.
	int hold_left;
	int next_hold_at;
	logic [7:0] pat_cycle;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			hold_left       <= 0;
			next_hold_at    <= 150;
			pat_cycle       <= '0;
		end else begin
			pat_cycle <= pat_cycle + 1'b1;
			if (hold_left != 0) begin
				hold_left       <= hold_left - 1;
				result_if.ready <= 1'b0;
			end else if (results_done >= next_hold_at) begin
				hold_left       <= 400;
				next_hold_at    <= next_hold_at + 450;
				long_holds      <= long_holds + 1;
				result_if.ready <= 1'b0;
			end else begin
				case (pat_cycle[7:6])
					2'd0: result_if.ready <= 1'b1;
					2'd1: result_if.ready <= $urandom_range(0, 3) != 0;
					2'd2: result_if.ready <= $urandom_range(0, 3) == 0;
					default: result_if.ready <= pat_cycle[0];
				endcase
			end
		end
	end

	// Monitor: every result word is checked against the oldest prediction.
	always @(posedge clk) begin
		aqi_result_t got;
		aqi_result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			got.sub_index        = result_if.sub_index;
			got.sub_category     = result_if.sub_category;
			got.found            = result_if.found;
			got.overall_index    = result_if.overall_index;
			got.overall_category = result_if.overall_category;
			got.set_done         = result_if.set_done;
			if (expected_q.size() == 0)
				note_failure($sformatf("result word with nothing pending: sub %0d overall %0d",
					got.sub_index, got.overall_index));
			else begin
				want = expected_q.pop_front();
				if (got.sub_index !== want.sub_index || got.sub_category !== want.sub_category
						|| got.found !== want.found
						|| got.overall_index !== want.overall_index
						|| got.overall_category !== want.overall_category
						|| got.set_done !== want.set_done)
					note_failure($sformatf({"word %0d: exp sub %0d cat %0d found %0d ",
						"overall %0d cat %0d done %0d, got sub %0d cat %0d found %0d ",
						"overall %0d cat %0d done %0d"}, results_done,
						want.sub_index, want.sub_category, want.found, want.overall_index,
						want.overall_category, want.set_done, got.sub_index,
						got.sub_category, got.found, got.overall_index,
						got.overall_category, got.set_done));
				if (want.found) hit_count++;
				else miss_count++;
				if (want.set_done) sets_closed++;
			end
			results_done++;
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", idle_cycles);
				$display("RESULT: ERROR");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int n;
		int k;
		int set_len;
		int p;
		int s;
		int c;
		bit noise;
		bit last;
		sample_if.valid         = 1'b0;
		sample_if.pollutant     = POLL_PM25;
		sample_if.concentration = '0;
		sample_if.last_of_set   = 1'b0;
		result_if.ready         = 1'b0;

		// Segment ends, category edges, rounding, gaps and clamping.
		queue_reading(POLL_PM25, 0, 0, 0);
		queue_reading(POLL_PM25, 120, 0, 0);          // exact half, rounds up
		queue_reading(POLL_PM25, 12000, 0, 0);
		queue_reading(POLL_PM25, 12050, 0, 0);        // gap between segments
		queue_reading(POLL_PM25, 12100, 0, 0);
		queue_reading(POLL_PM25, 35400, 1, 0);
		queue_reading(POLL_PM10, 155000, 0, 0);
		queue_reading(POLL_PM10, 254000, 0, 0);
		queue_reading(POLL_OZONE, 200, 0, 0);
		queue_reading(POLL_OZONE, 201, 1, 0);         // above the short ozone table
		queue_reading(POLL_CO, 12500, 0, 0);
		queue_reading(POLL_CO, 30400, 0, 0);
		queue_reading(POLL_CO, 30500, 0, 0);
		queue_reading(POLL_SO2, 1004000, 0, 0);
		queue_reading(POLL_SO2, 1004001, 0, 0);
		queue_reading(POLL_NO2, 2049000, 1, 0);
		queue_reading(3'd6, 1000, 0, 0);              // codes past the table
		queue_reading(3'd7, 4194303, 0, 0);
		queue_reading(POLL_PM25, -4194304, 0, 0);     // negatives clamp to zero
		queue_reading(POLL_NO2, -1, 0, 0);
		queue_reading(POLL_PM25, 4194303, 0, 0);
		queue_reading(POLL_SO2, 4194303, 1, 0);

		// Mostly well-formed sets of in-table readings, salted with noise.
		n = 0;
		while (n < RANDOM_ITEMS) begin
			set_len = $urandom_range(1, 6);
			for (k = 0; k < set_len; k++) begin
				noise = $urandom_range(0, 4) == 0;
				p = $urandom_range(0, NUM_POLL - 1);
				s = $urandom_range(0, bp_count[p] - 1);
				if (!noise) begin
					case ($urandom_range(0, 3))
						0: c = bp_c_lo[p][s];
						1: c = bp_c_hi[p][s];
						default: c = $urandom_range(bp_c_lo[p][s], bp_c_hi[p][s]);
					endcase
				end else begin
					case ($urandom_range(0, 2))
						0: c = bp_c_hi[p][s] + $urandom_range(1, 3);
						1: c = -int'($urandom_range(1, 4194304));
						default: c = $urandom_range(0, 8388607);
					endcase
					if ($urandom_range(0, 1) == 0) p = $urandom_range(0, 7);
				end
				last = (k == set_len - 1) || (noise && $urandom_range(0, 7) == 0);
				queue_reading(3'(p), c, last, (n % 150) == 0);
				n++;
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending_q.size() != 0 || expected_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("checked %0d result words: %0d in a segment, %0d in a gap or off the table",
			results_done, hit_count, miss_count);
		$display("%0d sets closed, %0d long receiver hold-offs, %0d mismatches",
			sets_closed, long_holds, error_count);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
src/aqic_pkg.sv
src/aqic_if.sv
src/air_quality_index_calc_core.sv
tb/tb_air_quality_index_calc_core.sv
